// File: hw/rtl/nrd_pkg.sv
// shared constants, types and command/status structs for the n-gram rank distance block
package nrd_pkg;

    localparam int PROFILE_DEPTH = 256;
    localparam int NGRAM_CHARS   = 5;
    localparam int CODE_W        = 40;
    localparam int USED_W        = 8 * NGRAM_CHARS;
    localparam int IDX_W         = $clog2(PROFILE_DEPTH);
    localparam int CNT_W         = $clog2(PROFILE_DEPTH + 1);
    localparam int DIST_W        = 24;
    localparam int MISS_W        = 9;
    localparam int PEN_W         = 16;

    localparam logic [CODE_W-1:0] CODE_MASK   = {CODE_W{1'b1}} >> (CODE_W - USED_W);
    localparam logic [PEN_W-1:0]  PEN_RESET   = PEN_W'(256);
    localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(PROFILE_DEPTH);
    localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
    localparam logic [MISS_W-1:0] MISS_MAX    = {MISS_W{1'b1}};

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [MISS_W-1:0] miss_t;
    typedef logic [PEN_W-1:0]  pen_t;

    typedef struct packed {
        logic capture;
        logic ref_write;
        logic test_ovf_set;
        logic scan_start;
        logic scan_step;
        logic score;
        logic emit;
    } nrd_cmd_t;

    typedef struct packed {
        logic last;
        logic rank_full;
        logic scan_done;
        logic out_busy;
    } nrd_sts_t;

endpackage

// File: hw/rtl/nrd_ctrl.sv
// controller state machine: sequences load, scan, score and result transfer
module nrd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_kind,
    output logic            in_ready,
    input  nrd_pkg::nrd_sts_t sts,
    output nrd_pkg::nrd_cmd_t cmd
);
    import nrd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_TEST  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_SCORE = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = in_kind ? ST_TEST : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.ref_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_TEST:
            begin
                if (sts.rank_full)
                begin
                    cmd.test_ovf_set = 1'b1;
                    state_next       = sts.last ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                cmd.score  = 1'b1;
                state_next = sts.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/nrd_datapath.sv
// datapath: reference table memory, scan pipeline, accumulators and output register
module nrd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  nrd_pkg::nrd_cmd_t cmd,
    output nrd_pkg::nrd_sts_t sts,
    input  logic              in_kind,
    input  nrd_pkg::code_t    in_code,
    input  logic              in_first,
    input  logic              in_last,
    input  logic              cfg_write,
    input  nrd_pkg::pen_t     cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nrd_pkg::dist_t    out_distance,
    output nrd_pkg::miss_t    out_unmatched,
    output logic              out_overflow
);
    import nrd_pkg::*;

    code_t ref_mem [PROFILE_DEPTH];

    code_t code_reg;
    logic  last_reg;
    code_t rd_data_reg;
    idx_t  rd_idx_reg;
    idx_t  hit_idx_reg;
    cnt_t  ref_count_reg, ref_count_next;
    logic  ref_ovf_reg, ref_ovf_next;
    cnt_t  rank_reg, rank_next;
    dist_t dist_reg, dist_next;
    miss_t miss_reg, miss_next;
    logic  test_ovf_reg, test_ovf_next;
    pen_t  penalty_reg, penalty_next;
    cnt_t  idx_reg, idx_next;
    logic  pend_reg, pend_next;
    logic  hit_reg, hit_next;
    logic  out_valid_reg, out_valid_next;
    dist_t out_dist_reg;
    miss_t out_miss_reg;
    logic  out_ovf_reg;

    logic  match_now;
    logic  issue;
    logic  ref_room;
    cnt_t  hit_ext;
    cnt_t  rank_diff;
    dist_t amount;
    logic [DIST_W:0] sum;

    assign ref_room  = ref_count_reg < DEPTH_CNT;
    assign match_now = pend_reg && !hit_reg && (rd_data_reg == code_reg);
    assign issue     = cmd.scan_step && !hit_reg && !match_now && (idx_reg < ref_count_reg);
    assign hit_ext   = CNT_W'(hit_idx_reg);
    assign rank_diff = (rank_reg >= hit_ext) ? (rank_reg - hit_ext) : (hit_ext - rank_reg);
    assign amount    = hit_reg ? DIST_W'(rank_diff) : DIST_W'(penalty_reg);
    assign sum       = {1'b0, dist_reg} + {1'b0, amount};

    assign sts.last      = last_reg;
    assign sts.rank_full = rank_reg >= DEPTH_CNT;
    assign sts.scan_done = hit_reg || (!pend_reg && (idx_reg == ref_count_reg));
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign out_distance  = out_dist_reg;
    assign out_unmatched = out_miss_reg;
    assign out_overflow  = out_ovf_reg;

    always_comb
    begin
        ref_count_next = ref_count_reg;
        ref_ovf_next   = ref_ovf_reg;
        rank_next      = rank_reg;
        dist_next      = dist_reg;
        miss_next      = miss_reg;
        test_ovf_next  = test_ovf_reg;
        penalty_next   = penalty_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;

        if (cfg_write)
        begin
            penalty_next = cfg_data;
        end

        // first on a transfer restarts the side that the kind selects
        if (cmd.capture && in_first)
        begin
            if (in_kind)
            begin
                rank_next     = '0;
                dist_next     = '0;
                miss_next     = '0;
                test_ovf_next = 1'b0;
            end
            else
            begin
                ref_count_next = '0;
                ref_ovf_next   = 1'b0;
            end
        end

        if (cmd.ref_write)
        begin
            if (ref_room)
            begin
                ref_count_next = ref_count_reg + 1'b1;
            end
            else
            begin
                ref_ovf_next = 1'b1;
            end
        end

        if (cmd.test_ovf_set)
        begin
            test_ovf_next = 1'b1;
        end

        if (cmd.scan_start)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            hit_next  = 1'b0;
        end

        if (cmd.scan_step)
        begin
            pend_next = issue;
            if (issue)
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (match_now)
            begin
                hit_next = 1'b1;
            end
        end

        if (cmd.score)
        begin
            rank_next = rank_reg + 1'b1;
            dist_next = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
            if (!hit_reg && (miss_reg != MISS_MAX))
            begin
                miss_next = miss_reg + 1'b1;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= '0;
            ref_ovf_reg   <= 1'b0;
            rank_reg      <= '0;
            dist_reg      <= '0;
            miss_reg      <= '0;
            test_ovf_reg  <= 1'b0;
            penalty_reg   <= PEN_RESET;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ref_count_reg <= ref_count_next;
            ref_ovf_reg   <= ref_ovf_next;
            rank_reg      <= rank_next;
            dist_reg      <= dist_next;
            miss_reg      <= miss_next;
            test_ovf_reg  <= test_ovf_next;
            penalty_reg   <= penalty_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers and reference memory
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            code_reg <= in_code & CODE_MASK;
            last_reg <= in_last;
        end
        if (cmd.ref_write && ref_room)
        begin
            ref_mem[ref_count_reg[IDX_W-1:0]] <= code_reg;
        end
        if (issue)
        begin
            rd_data_reg <= ref_mem[idx_reg[IDX_W-1:0]];
            rd_idx_reg  <= idx_reg[IDX_W-1:0];
        end
        if (cmd.scan_step && match_now)
        begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (cmd.emit)
        begin
            out_dist_reg <= dist_reg;
            out_miss_reg <= miss_reg;
            out_ovf_reg  <= test_ovf_reg || ref_ovf_reg;
        end
    end

endmodule

// File: hw/rtl/ngram_rank_distance.sv
// top level of the n-gram out-of-place rank distance block
//
// input channel (in_valid/in_ready): kind 0 loads ngram_code as the next
// reference rank, kind 1 scores it against the reference table as the next
// test rank. first restarts the rank of its kind; on a test it also clears
// the sums. a test transfer with last set produces one result transfer on
// the output channel (out_valid/out_ready): distance, unmatched_count and
// overflow. cfg_valid/cfg_ready writes missing_penalty, always ready.
// one item is in work at a time. a reference item is captured and then written
// into the table. a test item is captured, then scanned against the table up
// to and including the first match (all loaded entries on a miss), then scored:
// the table is one memory with one registered read port, scanned one entry per
// cycle. a test item past the profile depth is dropped and sets the overflow.
// a test item with last then hands its result to the output register, waiting
// while an earlier result is not yet taken.
// a result waits in the output register; new items are accepted meanwhile,
// and only a later result stalls until the receiver takes the waiting one.
// reset clears counts, sums and the output valid and sets the penalty to
// 256; the table contents stay unknown but are only read below the count.
module ngram_rank_distance (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [39:0]         ngram_code,
    input  logic                first,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [23:0]         distance,
    output logic [8:0]          unmatched_count,
    output logic                overflow,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         missing_penalty
);
    import nrd_pkg::*;

    nrd_cmd_t cmd;
    nrd_sts_t sts;

    assign cfg_ready = 1'b1;

    nrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (kind),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nrd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_kind       (kind),
        .in_code       (ngram_code),
        .in_first      (first),
        .in_last       (last),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (missing_penalty),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_distance  (distance),
        .out_unmatched (unmatched_count),
        .out_overflow  (overflow)
    );

endmodule

// File: hw/rtl/nrd_checker.sv
// port-level checker for the n-gram rank distance block, bound to the top level
module nrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] distance,
    input logic [8:0]  unmatched_count,
    input logic        overflow
);

    // result holds while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance)
            && $stable(unmatched_count) && $stable(overflow))
        else $error("result changed while stalled");

    // input item holds until transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input valid dropped before transfer");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while item in work");

    // a new result only rises after the block was busy in the emit state and in the state before it
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready) && $past(!in_ready, 2))
        else $error("result without a scored test item");

endmodule

bind ngram_rank_distance nrd_checker u_nrd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .distance        (distance),
    .unmatched_count (unmatched_count),
    .overflow        (overflow)
);
